// File: rtl/esc_pkg.sv
// ----------------------------------------------------------------------------
// esc_pkg
// Shared types, constants and the red table of the escape-time fractal pixel block.
// ----------------------------------------------------------------------------
package esc_pkg;

   localparam int FRAME_WIDTH     = 1200;
   localparam int FRAME_HEIGHT    = 720;
   localparam int ITERATION_LIMIT = 100;

   localparam int COL_W   = 11;
   localparam int ROW_W   = 10;
   localparam int COUNT_W = 7;
   localparam int RED_W   = 8;
   localparam int FX_W    = 32;
   localparam int PROD_W  = 2 * FX_W;

   localparam int N_W       = $clog2(ITERATION_LIMIT + 1);
   localparam int N_EXT_W   = 11;
   localparam int RED_LAST  = 100;

   localparam logic [FX_W-1:0] STEP_BASE   = FX_W'((64'd1 << 25) / FRAME_HEIGHT);
   localparam logic [FX_W-1:0] HALF_WIDTH  = FX_W'(FRAME_WIDTH / 2);
   localparam logic [FX_W-1:0] HALF_HEIGHT = FX_W'(FRAME_HEIGHT / 2);
   localparam logic [PROD_W-1:0] ESCAPE_BOUND = PROD_W'(64'd16 << 48);

   localparam logic [FX_W-1:0] ZOOM_RESET = FX_W'(16777);

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   typedef enum logic [2:0] {
      CSR_JULIA_MODE = 3'd0,
      CSR_OFFSET_X   = 3'd1,
      CSR_OFFSET_Y   = 3'd2,
      CSR_ZOOM       = 3'd3,
      CSR_C_REAL     = 3'd4,
      CSR_C_IMAG     = 3'd5
   } csr_index_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_SQUARE,
      BK_TEST
   } back_state_type;

   typedef struct packed {
      logic            julia_mode;
      logic [FX_W-1:0] view_offset_x;
      logic [FX_W-1:0] view_offset_y;
      logic [FX_W-1:0] zoom_adjust;
      logic [FX_W-1:0] julia_c_real;
      logic [FX_W-1:0] julia_c_imag;
   } esc_cfg_type;

   typedef struct packed {
      logic [FX_W-1:0] px;
      logic [FX_W-1:0] py;
      logic [FX_W-1:0] cr;
      logic [FX_W-1:0] ci;
   } esc_point_type;

   typedef struct packed {
      logic              full;
      logic              empty;
      logic [QCNT_W-1:0] count;
   } esc_queue_status_type;

   localparam logic [RED_W-1:0] RED_TABLE [0:RED_LAST] = '{
      8'd0,   8'd0,   8'd13,  8'd32,  8'd55,  8'd80,  8'd107, 8'd136, 8'd166, 8'd197,
      8'd230, 8'd7,   8'd42,  8'd77,  8'd113, 8'd150, 8'd187, 8'd225, 8'd8,   8'd47,
      8'd87,  8'd127, 8'd168, 8'd209, 8'd250, 8'd36,  8'd79,  8'd121, 8'd165, 8'd208,
      8'd252, 8'd40,  8'd85,  8'd129, 8'd174, 8'd220, 8'd10,  8'd56,  8'd102, 8'd148,
      8'd195, 8'd242, 8'd33,  8'd81,  8'd129, 8'd176, 8'd225, 8'd17,  8'd66,  8'd114,
      8'd164, 8'd213, 8'd6,   8'd56,  8'd106, 8'd156, 8'd206, 8'd0,   8'd51,  8'd101,
      8'd152, 8'd203, 8'd254, 8'd50,  8'd101, 8'd153, 8'd205, 8'd1,   8'd53,  8'd105,
      8'd157, 8'd210, 8'd7,   8'd60,  8'd113, 8'd166, 8'd219, 8'd16,  8'd70,  8'd123,
      8'd177, 8'd231, 8'd29,  8'd83,  8'd137, 8'd192, 8'd246, 8'd45,  8'd100, 8'd154,
      8'd209, 8'd8,   8'd64,  8'd119, 8'd174, 8'd230, 8'd29,  8'd85,  8'd141, 8'd197,
      8'd253
   };

endpackage

// File: rtl/esc_req_if.sv
// ----------------------------------------------------------------------------
// esc_req_if
// Pixel request channel: valid/ready with pixel column and row.
// ----------------------------------------------------------------------------
interface esc_req_if
   import esc_pkg::*;
();
   logic             valid;
   logic             ready;
   logic [COL_W-1:0] pixel_column;
   logic [ROW_W-1:0] pixel_row;

   modport source (output valid, output pixel_column, output pixel_row, input ready);
   modport sink   (input valid, input pixel_column, input pixel_row, output ready);
endinterface

// File: rtl/esc_rsp_if.sv
// ----------------------------------------------------------------------------
// esc_rsp_if
// Pixel result channel: valid/ready with iteration count and red level.
// ----------------------------------------------------------------------------
interface esc_rsp_if
   import esc_pkg::*;
();
   logic               valid;
   logic               ready;
   logic [COUNT_W-1:0] iteration_count;
   logic [RED_W-1:0]   red_level;

   modport source (output valid, output iteration_count, output red_level, input ready);
   modport sink   (input valid, input iteration_count, input red_level, output ready);
endinterface

// File: rtl/esc_csr.sv
// ----------------------------------------------------------------------------
// esc_csr
// APB-style register file holding mode, view offsets, zoom and Julia constant.
// ----------------------------------------------------------------------------
module esc_csr
   import esc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready,
   output esc_cfg_type           cfg
);

   esc_cfg_type   cfg_ff, cfg_in;
   csr_index_type index;
   logic          wr_en;

   assign index  = csr_index_type'(paddr[CSR_ADDR_W-1:2]);
   assign wr_en  = psel && penable && pwrite;
   assign pready = 1'b1;
   assign cfg    = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (index)
            CSR_JULIA_MODE: cfg_in.julia_mode    = pwdata[0];
            CSR_OFFSET_X:   cfg_in.view_offset_x = pwdata;
            CSR_OFFSET_Y:   cfg_in.view_offset_y = pwdata;
            CSR_ZOOM:       cfg_in.zoom_adjust   = pwdata;
            CSR_C_REAL:     cfg_in.julia_c_real  = pwdata;
            CSR_C_IMAG:     cfg_in.julia_c_imag  = pwdata;
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (index)
         CSR_JULIA_MODE: prdata = {{(CSR_DATA_W-1){1'b0}}, cfg_ff.julia_mode};
         CSR_OFFSET_X:   prdata = cfg_ff.view_offset_x;
         CSR_OFFSET_Y:   prdata = cfg_ff.view_offset_y;
         CSR_ZOOM:       prdata = cfg_ff.zoom_adjust;
         CSR_C_REAL:     prdata = cfg_ff.julia_c_real;
         CSR_C_IMAG:     prdata = cfg_ff.julia_c_imag;
         default:        prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{julia_mode:    1'b0,
                     view_offset_x: '0,
                     view_offset_y: '0,
                     zoom_adjust:   ZOOM_RESET,
                     julia_c_real:  '0,
                     julia_c_imag:  '0};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// File: rtl/esc_front.sv
// ----------------------------------------------------------------------------
// esc_front
// Accepts pixels, maps them to the complex plane and picks c by mode.
// ----------------------------------------------------------------------------
module esc_front
   import esc_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   esc_req_if.sink              req,
   input  esc_cfg_type          cfg,
   input  esc_queue_status_type q_status,
   output logic                 q_push,
   output esc_point_type        q_data
);

   logic            valid_ff, valid_in;
   logic [FX_W-1:0] prod_x_ff, prod_x_in;
   logic [FX_W-1:0] prod_y_ff, prod_y_in;
   logic [FX_W-1:0] step;
   logic [FX_W-1:0] col_ofs;
   logic [FX_W-1:0] row_ofs;
   logic            accept;

   assign step    = STEP_BASE + cfg.zoom_adjust;
   assign col_ofs = FX_W'(req.pixel_column) - HALF_WIDTH;
   assign row_ofs = FX_W'(req.pixel_row) - HALF_HEIGHT;

   assign q_push    = valid_ff && !q_status.full;
   assign req.ready = !valid_ff || q_push;
   assign accept    = req.valid && req.ready;

   always_comb begin
      valid_in  = valid_ff;
      prod_x_in = prod_x_ff;
      prod_y_in = prod_y_ff;
      if (q_push) begin
         valid_in = 1'b0;
      end
      if (accept) begin
         valid_in  = 1'b1;
         prod_x_in = step * col_ofs;
         prod_y_in = step * row_ofs;
      end
   end

   always_comb begin
      q_data.px = prod_x_ff + cfg.view_offset_x;
      q_data.py = prod_y_ff + cfg.view_offset_y;
      q_data.cr = cfg.julia_mode ? cfg.julia_c_real : q_data.px;
      q_data.ci = cfg.julia_mode ? cfg.julia_c_imag : q_data.py;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      prod_x_ff <= prod_x_in;
      prod_y_ff <= prod_y_in;
   end

endmodule

// File: rtl/esc_queue.sv
// ----------------------------------------------------------------------------
// esc_queue
// Short point queue between the mapping front and the iteration back.
// ----------------------------------------------------------------------------
module esc_queue
   import esc_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  esc_point_type        push_data,
   input  logic                 pop,
   output esc_point_type        pop_data,
   output esc_queue_status_type status
);

   esc_point_type     entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;

   function automatic logic [QPTR_W-1:0] ptr_next(input logic [QPTR_W-1:0] p);
      return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   assign status.full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);
   assign status.count = count_ff;
   assign pop_data     = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop  ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// File: rtl/esc_back.sv
// ----------------------------------------------------------------------------
// esc_back
// Iteration engine: z = z^2 + c, each step through the square and test states, plus result slot.
// ----------------------------------------------------------------------------
module esc_back
   import esc_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  esc_queue_status_type q_status,
   input  esc_point_type        q_data,
   output logic                 q_pop,
   esc_rsp_if.source            rsp
);

   back_state_type state_ff, state_in;

   logic [FX_W-1:0]   x_ff, x_in;
   logic [FX_W-1:0]   y_ff, y_in;
   logic [FX_W-1:0]   cr_ff, cr_in;
   logic [FX_W-1:0]   ci_ff, ci_in;
   logic [N_W-1:0]    n_ff, n_in;
   logic [PROD_W-1:0] xx_ff, xx_in;
   logic [PROD_W-1:0] yy_ff, yy_in;
   logic [PROD_W-1:0] xy_ff, xy_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [COUNT_W-1:0] rsp_count_ff, rsp_count_in;
   logic [RED_W-1:0]   rsp_red_ff, rsp_red_in;

   logic               load;
   logic               square_en;
   logic               update;
   logic               emit;
   logic               slot_free;
   logic               escaped;
   logic               at_limit;
   logic               done;
   logic [PROD_W-1:0]  mag;
   logic [N_EXT_W-1:0] n_ext;
   logic [6:0]         red_idx;

   assign mag       = xx_ff + yy_ff;
   assign escaped   = (mag >= ESCAPE_BOUND);
   assign at_limit  = (n_ff == N_W'(ITERATION_LIMIT));
   assign done      = at_limit || escaped;
   assign slot_free = !rsp_valid_ff || rsp.ready;

   assign n_ext   = N_EXT_W'(n_ff);
   assign red_idx = (n_ext > N_EXT_W'(RED_LAST)) ? 7'(RED_LAST) : n_ext[6:0];

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_IDLE:   if (!q_status.empty) state_in = BK_SQUARE;
         BK_SQUARE: state_in = BK_TEST;
         BK_TEST: begin
            if (!done) begin
               state_in = BK_SQUARE;
            end else if (slot_free) begin
               state_in = BK_IDLE;
            end
         end
         default:   state_in = BK_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      load      = 1'b0;
      square_en = 1'b0;
      update    = 1'b0;
      emit      = 1'b0;
      unique case (state_ff)
         BK_IDLE:   load      = !q_status.empty;
         BK_SQUARE: square_en = 1'b1;
         BK_TEST: begin
            update = !done;
            emit   = done && slot_free;
         end
         default:   load = 1'b0;
      endcase
   end

   assign q_pop = load;

   always_comb begin
      x_in  = x_ff;
      y_in  = y_ff;
      cr_in = cr_ff;
      ci_in = ci_ff;
      n_in  = n_ff;
      xx_in = xx_ff;
      yy_in = yy_ff;
      xy_in = xy_ff;
      if (load) begin
         x_in  = q_data.px;
         y_in  = q_data.py;
         cr_in = q_data.cr;
         ci_in = q_data.ci;
         n_in  = '0;
      end
      if (square_en) begin
         xx_in = $signed(x_ff) * $signed(x_ff);
         yy_in = $signed(y_ff) * $signed(y_ff);
         xy_in = $signed(x_ff) * $signed(y_ff);
      end
      if (update) begin
         x_in = xx_ff[55:24] - yy_ff[55:24] + cr_ff;
         y_in = xy_ff[54:23] + ci_ff;
         n_in = n_ff + 1'b1;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      rsp_count_in = rsp_count_ff;
      rsp_red_in   = rsp_red_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_count_in = COUNT_W'(n_ff);
         rsp_red_in   = RED_TABLE[red_idx];
      end
   end

   assign rsp.valid           = rsp_valid_ff;
   assign rsp.iteration_count = rsp_count_ff;
   assign rsp.red_level       = rsp_red_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      x_ff         <= x_in;
      y_ff         <= y_in;
      cr_ff        <= cr_in;
      ci_ff        <= ci_in;
      n_ff         <= n_in;
      xx_ff        <= xx_in;
      yy_ff        <= yy_in;
      xy_ff        <= xy_in;
      rsp_count_ff <= rsp_count_in;
      rsp_red_ff   <= rsp_red_in;
   end

endmodule

// File: rtl/escape_time_fractal_pixel.sv
// ----------------------------------------------------------------------------
// escape_time_fractal_pixel
// Escape-time Mandelbrot / Julia evaluator for one pixel per transaction.
// ----------------------------------------------------------------------------
// Usage:
//   req_bus  : pixel column and row, valid/ready.
//   rsp_bus  : iteration count and red byte, one transaction per request, in order.
//   psel/... : APB-style register port; write only while the block is idle.
// A front stage maps the pixel to Q8.24 coordinates and hands the
// point to a two-entry queue; the back engine runs z = z^2 + c.
// In each iteration the squares and cross product are registered, then the
// escape test and update run. The engine evaluates one pixel at a time and
// takes the next from the queue when it returns to idle.
// The front keeps accepting pixels until its register and the queue are full,
// and the engine keeps working while a result waits in the output register;
// it only holds when a second result is ready and the receiver has not taken
// the first.
// Reset (synchronous, active high) empties the queue, output and engine and
// loads the register reset values.
// ----------------------------------------------------------------------------
module escape_time_fractal_pixel
   import esc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   esc_req_if.sink               req_bus,
   esc_rsp_if.source             rsp_bus,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   esc_cfg_type          cfg;
   esc_queue_status_type q_status;
   esc_point_type        q_wr_data;
   esc_point_type        q_rd_data;
   logic                 q_push;
   logic                 q_pop;

   esc_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   esc_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req      (req_bus),
      .cfg      (cfg),
      .q_status (q_status),
      .q_push   (q_push),
      .q_data   (q_wr_data)
   );

   esc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_wr_data),
      .pop       (q_pop),
      .pop_data  (q_rd_data),
      .status    (q_status)
   );

   esc_back u_back (
      .clock    (clock),
      .reset    (reset),
      .q_status (q_status),
      .q_data   (q_rd_data),
      .q_pop    (q_pop),
      .rsp      (rsp_bus)
   );

   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      q_status.count <= QCNT_W'(QUEUE_DEPTH))
      else $error("queue count beyond depth");

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_status.full)
      else $error("push into full queue");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_status.empty)
      else $error("pop from empty queue");

   a_zero_red: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && (rsp_bus.iteration_count == '0)) |-> (rsp_bus.red_level == '0))
      else $error("nonzero red for zero iterations");

endmodule

// File: tb/tb_escape_time_fractal_pixel.sv
// ----------------------------------------------------------------------------
// tb_escape_time_fractal_pixel
// Self-checking bench for the escape-time Mandelbrot / Julia pixel evaluator.
// A directed pixel list runs under the reset view first. Then ten phases
// follow, each with a new register setting (the signed extremes among them).
// Each phase sends random pixels, mostly inside the frame, while the request
// and result sides idle and stall in turn. A local fixed-point predictor
// computes the count and red byte of each accepted pixel, and results are
// compared in order.
// ----------------------------------------------------------------------------
module tb_escape_time_fractal_pixel;
   import esc_pkg::*;

   localparam int N_DIRECTED      = 20;
   localparam int N_PHASES        = 10;
   localparam int ITEMS_PER_PHASE = 75;
   localparam int CYCLE_LIMIT     = 1000000;
   localparam int DRAIN_CYCLES    = 2 * ITERATION_LIMIT + 10;

   localparam logic [FX_W-1:0] BASE_STEP = FX_W'((64'd1 << 25) / FRAME_HEIGHT);
   localparam logic [63:0]     ESCAPE_SQ = 64'd16 << 48;

   localparam logic [RED_W-1:0] RED_BY_COUNT [0:100] = '{
      8'd0,   8'd0,   8'd13,  8'd32,  8'd55,  8'd80,  8'd107, 8'd136, 8'd166, 8'd197,
      8'd230, 8'd7,   8'd42,  8'd77,  8'd113, 8'd150, 8'd187, 8'd225, 8'd8,   8'd47,
      8'd87,  8'd127, 8'd168, 8'd209, 8'd250, 8'd36,  8'd79,  8'd121, 8'd165, 8'd208,
      8'd252, 8'd40,  8'd85,  8'd129, 8'd174, 8'd220, 8'd10,  8'd56,  8'd102, 8'd148,
      8'd195, 8'd242, 8'd33,  8'd81,  8'd129, 8'd176, 8'd225, 8'd17,  8'd66,  8'd114,
      8'd164, 8'd213, 8'd6,   8'd56,  8'd106, 8'd156, 8'd206, 8'd0,   8'd51,  8'd101,
      8'd152, 8'd203, 8'd254, 8'd50,  8'd101, 8'd153, 8'd205, 8'd1,   8'd53,  8'd105,
      8'd157, 8'd210, 8'd7,   8'd60,  8'd113, 8'd166, 8'd219, 8'd16,  8'd70,  8'd123,
      8'd177, 8'd231, 8'd29,  8'd83,  8'd137, 8'd192, 8'd246, 8'd45,  8'd100, 8'd154,
      8'd209, 8'd8,   8'd64,  8'd119, 8'd174, 8'd230, 8'd29,  8'd85,  8'd141, 8'd197,
      8'd253
   };

   typedef struct packed {
      logic [COUNT_W-1:0] iterations;
      logic [RED_W-1:0]   red;
   } escape_result_type;

   typedef struct packed {
      logic [COL_W-1:0]  col;
      logic [ROW_W-1:0]  row;
      logic              typed;
      escape_result_type want;
   } pixel_case_type;

   typedef enum logic [1:0] {
      IDLE_NONE,
      IDLE_SENDER,
      IDLE_RECEIVER,
      IDLE_BOTH
   } idle_mode_type;

   // typed rows: frame center stays at the origin, far columns escape at once
   localparam pixel_case_type DIRECTED_PIXELS [N_DIRECTED] = '{
      '{11'd600,  10'd360,  1'b1, '{7'd100, 8'd253}},
      '{11'd2047, 10'd1023, 1'b1, '{7'd0,   8'd0}},
      '{11'd2047, 10'd0,    1'b1, '{7'd0,   8'd0}},
      '{11'd2047, 10'd360,  1'b1, '{7'd0,   8'd0}},
      '{11'd0,    10'd0,    1'b0, '{7'd0,   8'd0}},
      '{11'd1199, 10'd719,  1'b0, '{7'd0,   8'd0}},
      '{11'd0,    10'd719,  1'b0, '{7'd0,   8'd0}},
      '{11'd1199, 10'd0,    1'b0, '{7'd0,   8'd0}},
      '{11'd0,    10'd360,  1'b0, '{7'd0,   8'd0}},
      '{11'd1199, 10'd360,  1'b0, '{7'd0,   8'd0}},
      '{11'd600,  10'd0,    1'b0, '{7'd0,   8'd0}},
      '{11'd600,  10'd719,  1'b0, '{7'd0,   8'd0}},
      '{11'd600,  10'd1023, 1'b0, '{7'd0,   8'd0}},
      '{11'd1024, 10'd512,  1'b0, '{7'd0,   8'd0}},
      '{11'd1023, 10'd511,  1'b0, '{7'd0,   8'd0}},
      '{11'd599,  10'd359,  1'b0, '{7'd0,   8'd0}},
      '{11'd601,  10'd361,  1'b0, '{7'd0,   8'd0}},
      '{11'd300,  10'd360,  1'b0, '{7'd0,   8'd0}},
      '{11'd700,  10'd360,  1'b0, '{7'd0,   8'd0}},
      '{11'd600,  10'd96,   1'b0, '{7'd0,   8'd0}}
   };

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   esc_req_if req_bus ();
   esc_rsp_if rsp_bus ();

   escape_time_fractal_pixel DUT (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   // register mirror
   logic            view_julia;
   logic [FX_W-1:0] view_off_x;
   logic [FX_W-1:0] view_off_y;
   logic [FX_W-1:0] view_zoom;
   logic [FX_W-1:0] view_c_re;
   logic [FX_W-1:0] view_c_im;

   escape_result_type pending_results [$];

   int req_idle_pct;
   int rsp_stall_pct;
   int mismatches;
   int pixels_sent;
   int results_checked;
   int julia_pixels;
   int escaped_at_once;
   int reached_limit;
   int settings_used;
   int cycles;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [63:0] exact_square(input logic [FX_W-1:0] a);
      longint s;
      s = longint'(signed'(a));
      return 64'(s * s);
   endfunction

   function automatic logic [FX_W-1:0] fx_product(input logic [FX_W-1:0] a,
                                                  input logic [FX_W-1:0] b,
                                                  input int shift);
      longint p;
      p = longint'(signed'(a)) * longint'(signed'(b));
      return FX_W'(p >>> shift);
   endfunction

   function automatic escape_result_type escape_count(input logic [COL_W-1:0] col,
                                                      input logic [ROW_W-1:0] row);
      logic [FX_W-1:0]   step, px, py, cr, ci, x, y, nx;
      int                n;
      escape_result_type r;
      step = BASE_STEP + view_zoom;
      px   = step * FX_W'(int'(col) - FRAME_WIDTH / 2) + view_off_x;
      py   = step * FX_W'(int'(row) - FRAME_HEIGHT / 2) + view_off_y;
      cr   = view_julia ? view_c_re : px;
      ci   = view_julia ? view_c_im : py;
      x    = px;
      y    = py;
      n    = 0;
      while (n < ITERATION_LIMIT && exact_square(x) + exact_square(y) < ESCAPE_SQ) begin
         nx = fx_product(x, x, 24) - fx_product(y, y, 24) + cr;
         y  = fx_product(x, y, 23) + ci;
         x  = nx;
         n++;
      end
      r.iterations = COUNT_W'(n);
      r.red        = RED_BY_COUNT[(n > 100) ? 100 : n];
      return r;
   endfunction

   task automatic write_csr(input csr_index_type idx, input logic [FX_W-1:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= CSR_ADDR_W'({idx, 2'b00});
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      case (idx)
         CSR_JULIA_MODE: view_julia = value[0];
         CSR_OFFSET_X:   view_off_x = value;
         CSR_OFFSET_Y:   view_off_y = value;
         CSR_ZOOM:       view_zoom  = value;
         CSR_C_REAL:     view_c_re  = value;
         CSR_C_IMAG:     view_c_im  = value;
         default: ;
      endcase
   endtask

   task automatic load_view(input logic julia, input logic [FX_W-1:0] off_x,
                            input logic [FX_W-1:0] off_y, input logic [FX_W-1:0] zoom,
                            input logic [FX_W-1:0] c_re, input logic [FX_W-1:0] c_im);
      write_csr(CSR_JULIA_MODE, {31'd0, julia});
      write_csr(CSR_OFFSET_X, off_x);
      write_csr(CSR_OFFSET_Y, off_y);
      write_csr(CSR_ZOOM, zoom);
      write_csr(CSR_C_REAL, c_re);
      write_csr(CSR_C_IMAG, c_im);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      settings_used++;
   endtask

   task automatic wait_drained();
      while (pending_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic send_pixel(input logic [COL_W-1:0] col, input logic [ROW_W-1:0] row,
                             input logic typed, input escape_result_type typed_want);
      int                gap;
      escape_result_type predicted;
      gap = 0;
      while ($urandom_range(99) < req_idle_pct) gap++;
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid        <= 1'b1;
      req_bus.pixel_column <= col;
      req_bus.pixel_row    <= row;
      do @(posedge clock); while (!req_bus.ready);
      predicted = escape_count(col, row);
      pending_results.push_back(typed ? typed_want : predicted);
      pixels_sent++;
      if (view_julia) julia_pixels++;
      if (predicted.iterations == 0) escaped_at_once++;
      if (predicted.iterations == COUNT_W'(ITERATION_LIMIT)) reached_limit++;
   endtask

   task automatic set_idle(input idle_mode_type mode);
      case (mode)
         IDLE_NONE:     begin req_idle_pct = 0;  rsp_stall_pct = 0;  end
         IDLE_SENDER:   begin req_idle_pct = 48; rsp_stall_pct = 0;  end
         IDLE_RECEIVER: begin req_idle_pct = 0;  rsp_stall_pct = 48; end
         default:       begin req_idle_pct = 31; rsp_stall_pct = 31; end
      endcase
   endtask

   // result side: random stalls, in-order compare
   always @(posedge clock) begin
      escape_result_type want;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (pending_results.size() == 0) begin
               mismatches++;
               $display("%0t: unexpected transaction count=%0d red=%0d", $time,
                        rsp_bus.iteration_count, rsp_bus.red_level);
            end else begin
               want = pending_results.pop_front();
               results_checked++;
               if (rsp_bus.iteration_count !== want.iterations) begin
                  mismatches++;
                  $display("%0t: iteration_count expected %0d actual %0d", $time,
                           want.iterations, rsp_bus.iteration_count);
               end
               if (rsp_bus.red_level !== want.red) begin
                  mismatches++;
                  $display("%0t: red_level expected %0d actual %0d", $time,
                           want.red, rsp_bus.red_level);
               end
            end
         end
         rsp_bus.ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles == CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d transactions outstanding", $time,
                  pending_results.size());
         $display("Verification failed");
         $finish;
      end
   end

   initial begin
      logic [COL_W-1:0] col;
      logic [ROW_W-1:0] row;
      logic [FX_W-1:0]  off_x, off_y, zoom, c_re, c_im;
      logic             julia;

      reset                = 1'b1;
      psel                 = 1'b0;
      penable              = 1'b0;
      pwrite               = 1'b0;
      paddr                = '0;
      pwdata               = '0;
      req_bus.valid        = 1'b0;
      req_bus.pixel_column = '0;
      req_bus.pixel_row    = '0;
      rsp_bus.ready        = 1'b0;
      view_julia           = 1'b0;
      view_off_x           = '0;
      view_off_y           = '0;
      view_zoom            = FX_W'(16777);
      view_c_re            = '0;
      view_c_im            = '0;
      mismatches           = 0;
      pixels_sent          = 0;
      results_checked      = 0;
      julia_pixels         = 0;
      escaped_at_once      = 0;
      reached_limit        = 0;
      settings_used        = 1;
      cycles               = 0;
      set_idle(IDLE_NONE);

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (DIRECTED_PIXELS[i])
         send_pixel(DIRECTED_PIXELS[i].col, DIRECTED_PIXELS[i].row,
                    DIRECTED_PIXELS[i].typed, DIRECTED_PIXELS[i].want);

      for (int p = 1; p <= N_PHASES; p++) begin
         req_bus.valid <= 1'b0;
         wait_drained();
         julia = p[0];
         off_x = $urandom_range(32'h0200_0000) - 32'h0100_0000;
         off_y = $urandom_range(32'h0200_0000) - 32'h0100_0000;
         zoom  = $urandom_range(80000) - 32'd46000;
         c_re  = $urandom_range(32'h0200_0000) - 32'h0100_0000;
         c_im  = $urandom_range(32'h0200_0000) - 32'h0100_0000;
         case (p)
            3: begin
               off_x = 32'h7FFF_FFFF; off_y = 32'h7FFF_FFFF; zoom = 32'h7FFF_FFFF;
               c_re  = 32'h7FFF_FFFF; c_im  = 32'h7FFF_FFFF;
            end
            6: begin
               off_x = 32'h8000_0000; off_y = 32'h8000_0000; zoom = 32'h8000_0000;
               c_re  = 32'h8000_0000; c_im  = 32'h8000_0000;
            end
            8: zoom = $urandom;
            9: zoom = -BASE_STEP;
            default: ;
         endcase
         load_view(julia, off_x, off_y, zoom, c_re, c_im);
         set_idle(idle_mode_type'(p % 4));
         for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
            if ($urandom_range(99) < 85) begin
               col = COL_W'($urandom_range(FRAME_WIDTH - 1));
               row = ROW_W'($urandom_range(FRAME_HEIGHT - 1));
            end else begin
               col = COL_W'($urandom_range(2047));
               row = ROW_W'($urandom_range(1023));
            end
            send_pixel(col, row, 1'b0, '0);
         end
      end
      req_bus.valid <= 1'b0;

      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d pixels under %0d view settings, %0d results checked",
               pixels_sent, settings_used, results_checked);
      $display("Julia-mode pixels %0d, escaped at once %0d, ran to the limit %0d",
               julia_pixels, escaped_at_once, reached_limit);
      if (mismatches == 0 && pending_results.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

// File: sim.f
rtl/esc_pkg.sv
rtl/esc_req_if.sv
rtl/esc_rsp_if.sv
rtl/esc_csr.sv
rtl/esc_front.sv
rtl/esc_queue.sv
rtl/esc_back.sv
rtl/escape_time_fractal_pixel.sv
tb/tb_escape_time_fractal_pixel.sv
